[rtl/frame_ring_with_channel_hop_core_assert.svh]
// assertion macros shared by the frame ring core
`ifndef FRAME_RING_WITH_CHANNEL_HOP_CORE_ASSERT_SVH
`define FRAME_RING_WITH_CHANNEL_HOP_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FRCH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define FRCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/frch_pkg.sv]
// package with the item types, command codes and constants of the frame ring core
`default_nettype none

package frch_pkg;

  // default geometry of the ring
  localparam int unsigned SLOTS_DEF     = 32;
  localparam int unsigned FRAME_MAX_DEF = 512;

  // hop timer constants
  localparam logic [31:0] HOP_DEFAULT_MS = 32'd500;
  localparam logic [7:0]  CHANNEL_TOP    = 8'd13;

  // fixed field widths and the register index bit
  localparam int unsigned OUT_LEN_W = 10;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned REG_IDX_BIT = 2;

  // item commands
  typedef enum logic [2:0] {
    CMD_BYTE   = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_SET_CH = 3'd3,
    CMD_START  = 3'd4,
    CMD_STOP   = 3'd5
  } cmd_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_HOP_INTERVAL  = 1'b0,
    REG_START_CHANNEL = 1'b1
  } reg_idx_e;

  // one input item
  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        data_byte;
    logic              frame_end;
    logic signed [7:0] rssi;
    logic [31:0]       now_ms;
    logic [7:0]        new_channel;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic                 out_valid;
    logic [7:0]           out_byte;
    logic [OUT_LEN_W-1:0] out_len;
    logic signed [7:0]    out_rssi;
    logic [31:0]          out_timestamp;
    logic                 out_frame_last;
    logic                 running;
    logic [7:0]           channel;
    logic [31:0]          frame_count;
    logic [31:0]          dropped_count;
  } out_item_t;

  // requests from the ring control to the hop timer
  typedef struct packed {
    logic start;
    logic tick;
    logic set_ch;
  } hop_ctrl_t;

endpackage

`default_nettype wire

[rtl/frch_frame_mem.sv]
// byte store of all ring slots, one write and one registered read port
`default_nettype none

module frch_frame_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/frch_slot_mem.sv]
// per-slot length, rssi and timestamp store with registered read and write bypass
`default_nettype none

module frch_slot_mem #(
  parameter int unsigned SLOTS = 32,
  parameter int unsigned SW    = 5,
  parameter int unsigned DW    = 50
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [SW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [SW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [SLOTS];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read every cycle; a write to the read address is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/frch_hop_timer.sv]
// channel register and automatic hop timer
`default_nettype none

module frch_hop_timer
  import frch_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire hop_ctrl_t   ctrl_i,
  input  wire logic [31:0] hop_interval_i,
  input  wire logic [7:0]  start_channel_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [7:0]  new_channel_i,
  output logic      [7:0]  chan_next_o
);

  logic        auto_q, auto_d;
  logic [7:0]  chan_q, chan_d;
  logic [31:0] last_hop_q, last_hop_d;
  logic [31:0] interval;
  logic [31:0] last_hop_eff;

  // channel modulo the top channel by conditional subtraction
  function automatic logic [7:0] chan_mod(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    for (int k = 4; k >= 0; k--) begin
      if (12'(r) >= (12'(CHANNEL_TOP) << k)) begin
        r = r - 8'(12'(CHANNEL_TOP) << k);
      end
    end
    return r;
  endfunction

  assign interval     = (hop_interval_i != 32'd0) ? hop_interval_i : HOP_DEFAULT_MS;
  assign last_hop_eff = (last_hop_q == 32'd0) ? now_ms_i : last_hop_q;

  // next channel state
  always_comb begin
    auto_d     = auto_q;
    chan_d     = chan_q;
    last_hop_d = last_hop_q;
    if (ctrl_i.start) begin
      auto_d     = (start_channel_i == 8'd0);
      chan_d     = (start_channel_i == 8'd0) ? 8'd1 : start_channel_i;
      last_hop_d = 32'd0;
    end else if (ctrl_i.set_ch) begin
      chan_d = new_channel_i;
      auto_d = 1'b0;
    end else if (ctrl_i.tick && auto_q) begin
      last_hop_d = last_hop_eff;
      if ((now_ms_i - last_hop_eff) >= interval) begin
        chan_d     = chan_mod(chan_q) + 8'd1;
        last_hop_d = now_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q     <= 1'b0;
      chan_q     <= 8'd0;
      last_hop_q <= 32'd0;
    end else begin
      auto_q     <= auto_d;
      chan_q     <= chan_d;
      last_hop_q <= last_hop_d;
    end
  end

  assign chan_next_o = chan_d;

endmodule

`default_nettype wire

[rtl/frame_ring_with_channel_hop_core.sv]
// top level of the captured-frame ring buffer with channel hop timer
//
// Items enter on the in channel (in_valid_i / in_stall_o / in_data_i), each carrying
// one command: frame byte, tick, pop byte, set channel, start or stop. Every item
// gives exactly one result on the out channel (out_valid_o / out_stall_i /
// out_data_o) with the popped byte, if any, and the status after that item.
// An item is taken into an input register, processed in one pass that updates the
// ring state and reads the byte store, and the result sits in the output register,
// from which it is shown and can transfer out; throughput one item per cycle while
// the receiver does not stall. The registered read of the byte store lands together
// with the result register.
// When the receiver stalls, the result holds and the input register keeps its item;
// the in channel stalls only when both are occupied.
// Reset leaves the block idle with empty ring, channel 0, hop interval 500 ms and
// start channel 0. Slot stores need no clearing: entries are read only once written.
// The user writes registers through APB only while idle; the block does not check.
`default_nettype none

`include "frame_ring_with_channel_hop_core_assert.svh"

module frame_ring_with_channel_hop_core
  import frch_pkg::*;
#(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned FRAME_MAX = FRAME_MAX_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // item channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_data_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_data_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned OW = $clog2(FRAME_MAX);
  localparam int unsigned LW = $clog2(FRAME_MAX + 1);
  localparam int unsigned AW = $clog2(SLOTS * FRAME_MAX);
  localparam int unsigned MW = LW + 8 + 32;

  // configuration registers
  logic [31:0] hop_interval_q;
  logic [7:0]  start_channel_q;
  logic        cfg_we;

  // pipeline registers
  logic        in_vld_q, out_vld_q;
  in_item_t    in_q;
  logic        en, proc;

  // ring state
  logic [SW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LW-1:0] wo_q, wo_d;
  logic [OW-1:0] ro_q, ro_d;
  logic          over_q, over_d;
  logic          run_q, run_d;
  logic [31:0]   popped_q, popped_d, dropped_q, dropped_d;

  // store access
  logic          byte_we, byte_re;
  logic [AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]    byte_rdata;
  logic          meta_we;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic [LW-1:0] meta_len;
  logic          pop_hit, pop_last;
  hop_ctrl_t     hop_ctrl;
  logic [7:0]    chan_next;

  // result register
  logic                 res_pop_q;
  logic [OUT_LEN_W-1:0] res_len_q;
  logic [7:0]           res_rssi_q;
  logic [31:0]          res_time_q;
  logic                 res_last_q;
  logic                 res_run_q;
  logic [7:0]           res_chan_q;
  logic [31:0]          res_popped_q, res_dropped_q;

  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    if (s == SW'(SLOTS - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  // configuration writes and reads
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_interval_q  <= HOP_DEFAULT_MS;
      start_channel_q <= 8'd0;
    end else if (cfg_we) begin
      case (paddr[REG_IDX_BIT])
        REG_HOP_INTERVAL:  hop_interval_q  <= pwdata;
        REG_START_CHANNEL: start_channel_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_IDX_BIT])
      REG_HOP_INTERVAL:  prdata = hop_interval_q;
      REG_START_CHANNEL: prdata = {24'd0, start_channel_q};
      default:           prdata = 32'd0;
    endcase
  end

  // pipeline flow: advance unless a shown result is stalled
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !en;
  assign proc       = in_vld_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (en) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  assign meta_len = meta_rdata[MW-1 -: LW];

  // command processing for the item in the input register
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    wo_d      = wo_q;
    ro_d      = ro_q;
    over_d    = over_q;
    run_d     = run_q;
    popped_d  = popped_q;
    dropped_d = dropped_q;
    byte_we   = 1'b0;
    meta_we   = 1'b0;
    pop_hit   = 1'b0;
    pop_last  = 1'b0;
    hop_ctrl  = '0;
    if (proc) begin
      case (in_q.cmd)
        CMD_BYTE: begin
          if (run_q) begin
            if (wo_q < LW'(FRAME_MAX)) begin
              byte_we = 1'b1;
              wo_d    = wo_q + 1'b1;
            end else begin
              over_d = 1'b1;
            end
            if (in_q.frame_end) begin
              if (over_d || (slot_next(head_q) == tail_q)) begin
                dropped_d = dropped_q + 32'd1;
              end else begin
                meta_we = 1'b1;
                head_d  = slot_next(head_q);
              end
              wo_d   = '0;
              over_d = 1'b0;
            end
          end
        end
        CMD_TICK: hop_ctrl.tick = run_q;
        CMD_POP: begin
          if (run_q && (tail_q != head_q)) begin
            pop_hit  = 1'b1;
            pop_last = ((LW + 1)'(ro_q) + 1'b1) >= (LW + 1)'(meta_len);
            if (pop_last) begin
              ro_d     = '0;
              tail_d   = slot_next(tail_q);
              popped_d = popped_q + 32'd1;
            end else begin
              ro_d = ro_q + 1'b1;
            end
          end
        end
        CMD_SET_CH: hop_ctrl.set_ch = run_q;
        CMD_START: begin
          hop_ctrl.start = 1'b1;
          head_d    = '0;
          tail_d    = '0;
          wo_d      = '0;
          ro_d      = '0;
          over_d    = 1'b0;
          popped_d  = 32'd0;
          dropped_d = 32'd0;
          run_d     = 1'b1;
        end
        CMD_STOP: run_d = 1'b0;
        default: ;
      endcase
    end
  end

  assign byte_re    = pop_hit;
  assign byte_waddr = AW'(head_q) * AW'(FRAME_MAX) + AW'(wo_q);
  assign byte_raddr = AW'(tail_q) * AW'(FRAME_MAX) + AW'(ro_q);
  assign meta_wdata = {wo_q + 1'b1, in_q.rssi, in_q.now_ms};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      wo_q      <= '0;
      ro_q      <= '0;
      over_q    <= 1'b0;
      run_q     <= 1'b0;
      popped_q  <= 32'd0;
      dropped_q <= 32'd0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      wo_q      <= wo_d;
      ro_q      <= ro_d;
      over_q    <= over_d;
      run_q     <= run_d;
      popped_q  <= popped_d;
      dropped_q <= dropped_d;
    end
  end

  frch_frame_mem #(
    .DEPTH (SLOTS * FRAME_MAX),
    .AW    (AW)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (in_q.data_byte),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  frch_slot_mem #(
    .SLOTS (SLOTS),
    .SW    (SW),
    .DW    (MW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (head_q),
    .wdata_i (meta_wdata),
    .raddr_i (tail_d),
    .rdata_o (meta_rdata)
  );

  frch_hop_timer u_hop_timer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (hop_ctrl),
    .hop_interval_i  (hop_interval_q),
    .start_channel_i (start_channel_q),
    .now_ms_i        (in_q.now_ms),
    .new_channel_i   (in_q.new_channel),
    .chan_next_o     (chan_next)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_pop_q     <= pop_hit;
      res_len_q     <= pop_hit ? OUT_LEN_W'(meta_len) : '0;
      res_rssi_q    <= pop_hit ? meta_rdata[39:32] : 8'd0;
      res_time_q    <= pop_hit ? meta_rdata[31:0] : 32'd0;
      res_last_q    <= pop_last;
      res_run_q     <= run_d;
      res_chan_q    <= chan_next;
      res_popped_q  <= popped_d;
      res_dropped_q <= dropped_d;
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    out_data_o                = '0;
    out_data_o.out_valid      = res_pop_q;
    out_data_o.out_byte       = res_pop_q ? byte_rdata : 8'd0;
    out_data_o.out_len        = res_len_q;
    out_data_o.out_rssi       = res_rssi_q;
    out_data_o.out_timestamp  = res_time_q;
    out_data_o.out_frame_last = res_last_q;
    out_data_o.running        = res_run_q;
    out_data_o.channel        = res_chan_q;
    out_data_o.frame_count    = res_popped_q;
    out_data_o.dropped_count  = res_dropped_q;
  end

  // checks
  `FRCH_ASSERT_IMPLIES(a_stall_only_when_full, clk_i, rst_ni,
    in_stall_o, out_valid_o && out_stall_i)
  `FRCH_ASSERT_IMPLIES(a_pop_while_running, clk_i, rst_ni,
    out_valid_o && out_data_o.out_valid, out_data_o.running)
  `FRCH_ASSERT_IMPLIES(a_last_needs_pop, clk_i, rst_ni,
    out_valid_o && out_data_o.out_frame_last, out_data_o.out_valid)
  `FRCH_ASSERT_NEXT(a_stop_blocks_store, clk_i, rst_ni,
    proc && (in_q.cmd == CMD_STOP), !byte_we)

endmodule

`default_nettype wire
